// ===== rtl/core/gmc_pkg.sv =====
package gmc_pkg;

  localparam int AXIS_CENTER_DEF = 32767;
  localparam int LEG_STEP_DEF    = 1311;

  localparam int AXIS_W     = 16;
  localparam int TIME_W     = 32;
  localparam int BTN_W      = 4;
  localparam int CMD_W      = 16;
  localparam int LEG_W      = 16;
  localparam int GAIN_W     = 15;
  localparam int GAP_W      = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // largest command magnitude, one bit short of the command width
  localparam int CMD_MAG_W = CMD_W - 1;
  localparam logic [CMD_MAG_W-1:0] CMD_MAX = '1;

  // button bit positions
  localparam int BTN_A = 0;
  localparam int BTN_B = 1;
  localparam int BTN_X = 2;
  localparam int BTN_Y = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEAD_ZONE      = 4'd0,
    REG_ROLL_DEAD_ZONE = 4'd1,
    REG_TOGGLE_GAP_MS  = 4'd2,
    REG_MAX_SPEED      = 4'd3,
    REG_MAX_YAW_RATE   = 4'd4,
    REG_MAX_ROLL       = 4'd5,
    REG_MIN_LEG        = 4'd6,
    REG_MAX_LEG        = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic              link_up;
    logic              report_valid;
    logic              input_enabled;
    logic              queue_busy;
    logic [AXIS_W-1:0] left_vertical;
    logic [AXIS_W-1:0] left_horizontal;
    logic [AXIS_W-1:0] right_horizontal;
    logic [AXIS_W-1:0] right_vertical;
    logic [BTN_W-1:0]  buttons;
    logic [TIME_W-1:0] now_ms;
    logic              standup_idle;
  } report_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] speed_cmd;
    logic signed [CMD_W-1:0] yaw_cmd;
    logic signed [CMD_W-1:0] roll_cmd;
    logic [LEG_W-1:0]        leg_length;
    logic                    cross_step_on;
    logic                    balance_on;
    logic                    standup_request;
    logic                    jump_request;
    logic                    connected;
  } command_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_write_t;

  typedef struct packed {
    logic [GAIN_W-1:0] dead_zone;
    logic [GAIN_W-1:0] roll_dead_zone;
    logic [GAP_W-1:0]  toggle_gap_ms;
    logic [GAIN_W-1:0] max_speed;
    logic [GAIN_W-1:0] max_yaw_rate;
    logic [GAIN_W-1:0] max_roll;
    logic [LEG_W-1:0]  min_leg;
    logic [LEG_W-1:0]  max_leg;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    dead_zone:      15'd3000,
    roll_dead_zone: 15'd300,
    toggle_gap_ms:  16'd300,
    max_speed:      15'd3277,
    max_yaw_rate:   15'd18432,
    max_roll:       15'd1229,
    min_leg:        16'd3801,
    max_leg:        16'd7537
  };

  // load enables for the three divider stages
  typedef struct packed {
    logic a;
    logic b;
    logic c;
  } cdiv_en_t;

endpackage

// ===== rtl/core/gmc_stream_if.sv =====
interface gmc_stream_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/gmc_cdiv.sv =====
// Floor division by a constant: reciprocal multiply, back-multiply, one correction.
// Quotients of 2**Q_W and above report sat instead.
module gmc_cdiv #(
  parameter int DIVISOR = 2 * gmc_pkg::AXIS_CENTER_DEF,
  parameter int N_W     = 33,
  parameter int Q_W     = 16
) (
  input  logic              clk,
  input  gmc_pkg::cdiv_en_t en,
  input  logic [N_W-1:0]    num,
  output logic [Q_W-1:0]    quo,
  output logic              sat
);

  localparam int D_W = $clog2(DIVISOR + 1);
  localparam int M_W = Q_W + D_W;
  localparam int C_W = (N_W > M_W) ? N_W : M_W;
  localparam int R_W = M_W - $clog2(DIVISOR) + 1;
  localparam int P_W = M_W + R_W;
  localparam longint unsigned RECIP_L = (64'd1 << M_W) / DIVISOR;
  localparam logic [R_W-1:0] RECIP = R_W'(RECIP_L);
  localparam logic [C_W-1:0] LIMIT = C_W'(DIVISOR) << Q_W;
  localparam logic [M_W-1:0] DIV_M = M_W'(DIVISOR);

  logic [M_W-1:0] n_clip;
  logic [P_W-1:0] prod_a;
  logic [M_W-1:0] n_a, n_b, pm_b, rem_b;
  logic [Q_W-1:0] q0_a, q0_b;
  logic           sat_a, sat_b;

  assign n_clip = M_W'(C_W'(num));
  assign prod_a = P_W'(n_clip) * P_W'(RECIP);
  assign rem_b  = n_b - pm_b;

  // estimate is exact or one low
  always_ff @(posedge clk) begin
    if (en.a) begin
      n_a   <= n_clip;
      sat_a <= (C_W'(num) >= LIMIT);
      q0_a  <= prod_a[M_W +: Q_W];
    end
    if (en.b) begin
      n_b   <= n_a;
      sat_b <= sat_a;
      q0_b  <= q0_a;
      pm_b  <= M_W'(q0_a) * DIV_M;
    end
    if (en.c) begin
      quo <= q0_b + Q_W'(rem_b >= DIV_M);
      sat <= sat_b;
    end
  end

endmodule

// ===== rtl/core/gamepad_report_to_motion_command.sv =====
// Channel   Dir  Payload                Handshake
// report    in   gmc_pkg::report_t      valid/ready
// command   out  gmc_pkg::command_t     valid/ready
// cfg       in   gmc_pkg::cfg_write_t   valid/ready, ready always high
//
// One report is taken per cycle unless the pipeline stalls; its command passes
// the three-stage constant divider behind each scaling multiply.
// rst (synchronous) empties the pipeline, clears the motion state and loads
// the register defaults. Every stage holds only while the one after it is full
// and blocked, so bubbles close up and reports keep entering while a command waits.
module gamepad_report_to_motion_command #(
  parameter int AXIS_CENTER = gmc_pkg::AXIS_CENTER_DEF,
  parameter int LEG_STEP    = gmc_pkg::LEG_STEP_DEF
) (
  input logic          clk,
  input logic          rst,
  gmc_stream_if.sink   report,
  gmc_stream_if.source command,
  gmc_stream_if.sink   cfg
);

  localparam int TWO_C   = 2 * AXIS_CENTER;
  localparam int HALF_C  = AXIS_CENTER / 2;
  localparam int AX_N_W  = 31;
  localparam int AX_Q_W  = gmc_pkg::CMD_MAG_W;
  localparam int LEG_N_W = 33;
  localparam int LEG_Q_W = gmc_pkg::LEG_W;
  localparam int NST     = 6;
  localparam logic signed [16:0] CENTER_S = 17'(AXIS_CENTER);

  typedef struct packed {
    logic                           link_up;
    logic                           report_valid;
    logic                           gate;
    logic [gmc_pkg::BTN_W-1:0]      buttons;
    logic [gmc_pkg::TIME_W-1:0]     now_ms;
    logic                           standup_idle;
    logic                           spd_zero;
    logic                           spd_pos;
    logic                           yaw_zero;
    logic                           yaw_pos;
    logic                           roll_zero;
    logic                           roll_pos;
    logic                           leg_neg;
  } side_t;

  typedef struct packed {
    logic                           link_up;
    logic                           report_valid;
    logic                           gate;
    logic [gmc_pkg::BTN_W-1:0]      buttons;
    logic [gmc_pkg::TIME_W-1:0]     now_ms;
    logic                           standup_idle;
    logic signed [gmc_pkg::CMD_W-1:0] speed_new;
    logic signed [gmc_pkg::CMD_W-1:0] yaw_new;
    logic signed [gmc_pkg::CMD_W-1:0] roll_new;
    logic [gmc_pkg::LEG_W-1:0]      leg_new;
  } fin_t;

  typedef struct packed {
    logic              zero;
    logic              pos;
    logic [AX_N_W-1:0] n;
  } axis_prep_t;

  function automatic axis_prep_t prep_axis(input logic [gmc_pkg::AXIS_W-1:0] axis,
                                           input logic [gmc_pkg::GAIN_W-1:0] dz,
                                           input logic [gmc_pkg::GAIN_W-1:0] full);
    logic signed [16:0] raw;
    logic [15:0]        mag;
    axis_prep_t         p;
    raw    = $signed({1'b0, axis}) - CENTER_S;
    p.pos  = (raw > 17'sd0);
    mag    = p.pos ? raw[15:0] : 16'(-raw);
    p.zero = (mag <= {1'b0, dz});
    // add half the center so the divide rounds to nearest
    p.n    = AX_N_W'(mag) * AX_N_W'(full) + AX_N_W'(HALF_C);
    return p;
  endfunction

  function automatic logic signed [gmc_pkg::CMD_W-1:0] axis_cmd(input logic zero,
                                                                input logic pos,
                                                                input logic [AX_Q_W-1:0] q,
                                                                input logic sat);
    logic [AX_Q_W-1:0]               mag;
    logic signed [gmc_pkg::CMD_W-1:0] val;
    mag = sat ? gmc_pkg::CMD_MAX : q;
    val = $signed({1'b0, mag});
    if (zero) begin
      return '0;
    end
    return pos ? -val : val;
  endfunction

  function automatic logic [gmc_pkg::LEG_W-1:0] clamp_leg(input logic signed [17:0] v,
                                                          input logic [gmc_pkg::LEG_W-1:0] lo,
                                                          input logic [gmc_pkg::LEG_W-1:0] hi);
    logic [gmc_pkg::LEG_W-1:0] res;
    priority if (v < $signed({2'b00, lo})) begin
      res = lo;
    end else if (v > $signed({2'b00, hi})) begin
      res = hi;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  // configuration
  gmc_pkg::cfg_regs_t cfg_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q <= gmc_pkg::CFG_RESET;
    end else if (cfg.valid) begin
      unique case (gmc_pkg::cfg_reg_t'(cfg.data.index))
        gmc_pkg::REG_DEAD_ZONE:      cfg_q.dead_zone      <= cfg.data.value[14:0];
        gmc_pkg::REG_ROLL_DEAD_ZONE: cfg_q.roll_dead_zone <= cfg.data.value[14:0];
        gmc_pkg::REG_TOGGLE_GAP_MS:  cfg_q.toggle_gap_ms  <= cfg.data.value;
        gmc_pkg::REG_MAX_SPEED:      cfg_q.max_speed      <= cfg.data.value[14:0];
        gmc_pkg::REG_MAX_YAW_RATE:   cfg_q.max_yaw_rate   <= cfg.data.value[14:0];
        gmc_pkg::REG_MAX_ROLL:       cfg_q.max_roll       <= cfg.data.value[14:0];
        gmc_pkg::REG_MIN_LEG:        cfg_q.min_leg        <= cfg.data.value;
        gmc_pkg::REG_MAX_LEG:        cfg_q.max_leg        <= cfg.data.value;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic [NST-1:0] stage_v;
  logic [NST-1:0] adv;
  logic           adv_out;
  logic           out_v;
  logic           fire;

  always_comb begin
    adv_out      = !out_v || command.ready;
    adv[NST-1]   = !stage_v[NST-1] || adv_out;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !stage_v[k] || adv[k+1];
    end
  end

  assign report.ready = adv[0];
  assign fire         = stage_v[NST-1] && adv_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= '0;
      out_v   <= 1'b0;
    end else begin
      if (adv[0]) begin
        stage_v[0] <= report.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          stage_v[k] <= stage_v[k-1];
        end
      end
      if (adv_out) begin
        out_v <= stage_v[NST-1];
      end
    end
  end

  // input register
  gmc_pkg::report_t in_q;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      in_q <= report.data;
    end
  end

  // scaling products
  axis_prep_t               spd_p, yaw_p, roll_p;
  logic signed [17:0]       leg_d;
  logic signed [16:0]       leg_diff;
  logic signed [34:0]       leg_num;
  side_t                    side1, side_a, side_b, side_c;
  logic [AX_N_W-1:0]        spd_n, yaw_n, roll_n;
  logic [LEG_N_W-1:0]       leg_n;

  always_comb begin
    spd_p    = prep_axis(in_q.left_vertical, cfg_q.dead_zone, cfg_q.max_speed);
    yaw_p    = prep_axis(in_q.right_horizontal, cfg_q.dead_zone, cfg_q.max_yaw_rate);
    roll_p   = prep_axis(in_q.left_horizontal, cfg_q.roll_dead_zone, cfg_q.max_roll);
    leg_d    = $signed(18'(TWO_C)) - $signed({2'b00, in_q.right_vertical});
    leg_diff = $signed({1'b0, cfg_q.max_leg}) - $signed({1'b0, cfg_q.min_leg});
    leg_num  = 35'(leg_diff) * 35'(leg_d) + 35'(AXIS_CENTER);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      side1.link_up      <= in_q.link_up;
      side1.report_valid <= in_q.report_valid;
      side1.gate         <= in_q.input_enabled && !in_q.queue_busy;
      side1.buttons      <= in_q.buttons;
      side1.now_ms       <= in_q.now_ms;
      side1.standup_idle <= in_q.standup_idle;
      side1.spd_zero     <= spd_p.zero;
      side1.spd_pos      <= spd_p.pos;
      side1.yaw_zero     <= yaw_p.zero;
      side1.yaw_pos      <= yaw_p.pos;
      side1.roll_zero    <= roll_p.zero;
      side1.roll_pos     <= roll_p.pos;
      side1.leg_neg      <= leg_num[34];
      spd_n              <= spd_p.n;
      yaw_n              <= yaw_p.n;
      roll_n             <= roll_p.n;
      leg_n              <= leg_num[LEG_N_W-1:0];
    end
    if (adv[2]) begin
      side_a <= side1;
    end
    if (adv[3]) begin
      side_b <= side_a;
    end
    if (adv[4]) begin
      side_c <= side_b;
    end
  end

  // dividers
  gmc_pkg::cdiv_en_t   div_en;
  logic [AX_Q_W-1:0]   spd_q, yaw_q, roll_q;
  logic [LEG_Q_W-1:0]  leg_q;
  logic                spd_sat, yaw_sat, roll_sat, leg_sat;

  assign div_en = '{a: adv[2], b: adv[3], c: adv[4]};

  gmc_cdiv #(.DIVISOR(AXIS_CENTER), .N_W(AX_N_W), .Q_W(AX_Q_W)) u_div_spd (
    .clk(clk), .en(div_en), .num(spd_n), .quo(spd_q), .sat(spd_sat)
  );

  gmc_cdiv #(.DIVISOR(AXIS_CENTER), .N_W(AX_N_W), .Q_W(AX_Q_W)) u_div_yaw (
    .clk(clk), .en(div_en), .num(yaw_n), .quo(yaw_q), .sat(yaw_sat)
  );

  gmc_cdiv #(.DIVISOR(AXIS_CENTER), .N_W(AX_N_W), .Q_W(AX_Q_W)) u_div_roll (
    .clk(clk), .en(div_en), .num(roll_n), .quo(roll_q), .sat(roll_sat)
  );

  gmc_cdiv #(.DIVISOR(TWO_C), .N_W(LEG_N_W), .Q_W(LEG_Q_W)) u_div_leg (
    .clk(clk), .en(div_en), .num(leg_n), .quo(leg_q), .sat(leg_sat)
  );

  // finish commands and leg mapping
  fin_t        fin, fin_next;
  logic [16:0] leg_sum;

  always_comb begin
    leg_sum               = {1'b0, cfg_q.min_leg} + {1'b0, leg_q};
    fin_next.link_up      = side_c.link_up;
    fin_next.report_valid = side_c.report_valid;
    fin_next.gate         = side_c.gate;
    fin_next.buttons      = side_c.buttons;
    fin_next.now_ms       = side_c.now_ms;
    fin_next.standup_idle = side_c.standup_idle;
    fin_next.speed_new    = axis_cmd(side_c.spd_zero, side_c.spd_pos, spd_q, spd_sat);
    fin_next.yaw_new      = axis_cmd(side_c.yaw_zero, side_c.yaw_pos, yaw_q, yaw_sat);
    fin_next.roll_new     = axis_cmd(side_c.roll_zero, side_c.roll_pos, roll_q, roll_sat);
    // a negative numerator lands below min_leg
    priority if (side_c.leg_neg) begin
      fin_next.leg_new = cfg_q.min_leg;
    end else if (leg_sat || (leg_sum > {1'b0, cfg_q.max_leg})) begin
      fin_next.leg_new = cfg_q.max_leg;
    end else begin
      fin_next.leg_new = leg_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NST-1]) begin
      fin <= fin_next;
    end
  end

  // motion state
  logic                             was_connected, was_connected_next;
  logic [gmc_pkg::BTN_W-1:0]        prev_buttons, prev_buttons_next;
  logic [gmc_pkg::TIME_W-1:0]       last_x_time, last_x_time_next;
  logic [gmc_pkg::TIME_W-1:0]       last_y_time, last_y_time_next;
  logic                             cross_toggled, cross_toggled_next;
  logic                             cross_enabled, cross_enabled_next;
  logic                             balance_flag, balance_flag_next;
  logic signed [gmc_pkg::CMD_W-1:0] speed_target, speed_target_next;
  logic signed [gmc_pkg::CMD_W-1:0] yaw_target, yaw_target_next;
  logic signed [gmc_pkg::CMD_W-1:0] roll_target, roll_target_next;
  logic [gmc_pkg::LEG_W-1:0]        leg_target, leg_target_next;
  logic [gmc_pkg::BTN_W-1:0]        rise;
  logic                             x_ok, y_ok;
  logic                             std_req, jump_req;
  gmc_pkg::command_t                out_q;

  always_comb begin
    was_connected_next = was_connected;
    prev_buttons_next  = prev_buttons;
    last_x_time_next   = last_x_time;
    last_y_time_next   = last_y_time;
    cross_toggled_next = cross_toggled;
    cross_enabled_next = cross_enabled;
    balance_flag_next  = balance_flag;
    speed_target_next  = speed_target;
    yaw_target_next    = yaw_target;
    roll_target_next   = roll_target;
    leg_target_next    = leg_target;
    std_req            = 1'b0;
    jump_req           = 1'b0;
    rise               = fin.buttons & ~prev_buttons;
    x_ok = ((fin.now_ms - last_x_time) >= gmc_pkg::TIME_W'(cfg_q.toggle_gap_ms));
    y_ok = ((fin.now_ms - last_y_time) >= gmc_pkg::TIME_W'(cfg_q.toggle_gap_ms));

    if (fire) begin
      if (fin.link_up) begin
        was_connected_next = 1'b1;
        if (fin.report_valid) begin
          if (fin.gate) begin
            speed_target_next = fin.speed_new;
            yaw_target_next   = fin.yaw_new;
            roll_target_next  = fin.roll_new;
            leg_target_next   = fin.leg_new;
          end
          if (rise[gmc_pkg::BTN_A] && fin.standup_idle) begin
            std_req = 1'b1;
          end
          if (rise[gmc_pkg::BTN_Y] && y_ok) begin
            balance_flag_next = !balance_flag;
            if (balance_flag_next) begin
              if (fin.standup_idle) begin
                std_req = 1'b1;
              end
            end else begin
              // dropping balance stops motion, ignoring the gate
              speed_target_next  = '0;
              yaw_target_next    = '0;
              cross_enabled_next = 1'b0;
            end
            last_y_time_next = fin.now_ms;
          end
          if (rise[gmc_pkg::BTN_B]) begin
            jump_req = 1'b1;
          end
          if (rise[gmc_pkg::BTN_X] && x_ok) begin
            if (!cross_toggled) begin
              leg_target_next = clamp_leg($signed({2'b00, leg_target_next}) +
                                          $signed(18'(LEG_STEP)),
                                          cfg_q.min_leg, cfg_q.max_leg);
              cross_enabled_next = 1'b1;
            end else begin
              leg_target_next = clamp_leg($signed({2'b00, leg_target_next}) -
                                          $signed(18'(LEG_STEP)),
                                          cfg_q.min_leg, cfg_q.max_leg);
              cross_enabled_next = 1'b0;
            end
            cross_toggled_next = !cross_toggled;
            last_x_time_next   = fin.now_ms;
          end
          prev_buttons_next = fin.buttons;
        end
      end else if (was_connected) begin
        was_connected_next = 1'b0;
        if (fin.gate) begin
          speed_target_next = '0;
          yaw_target_next   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_connected <= 1'b0;
      prev_buttons  <= '0;
      last_x_time   <= '0;
      last_y_time   <= '0;
      cross_toggled <= 1'b0;
      cross_enabled <= 1'b0;
      balance_flag  <= 1'b0;
      speed_target  <= '0;
      yaw_target    <= '0;
      roll_target   <= '0;
      leg_target    <= '0;
    end else begin
      was_connected <= was_connected_next;
      prev_buttons  <= prev_buttons_next;
      last_x_time   <= last_x_time_next;
      last_y_time   <= last_y_time_next;
      cross_toggled <= cross_toggled_next;
      cross_enabled <= cross_enabled_next;
      balance_flag  <= balance_flag_next;
      speed_target  <= speed_target_next;
      yaw_target    <= yaw_target_next;
      roll_target   <= roll_target_next;
      leg_target    <= leg_target_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_q.speed_cmd       <= speed_target_next;
      out_q.yaw_cmd         <= yaw_target_next;
      out_q.roll_cmd        <= roll_target_next;
      out_q.leg_length      <= leg_target_next;
      out_q.cross_step_on   <= cross_enabled_next;
      out_q.balance_on      <= balance_flag_next;
      out_q.standup_request <= std_req;
      out_q.jump_request    <= jump_req;
      out_q.connected       <= was_connected_next;
    end
  end

  assign command.valid = out_v;
  assign command.data  = out_q;

`ifndef ASSERT_OFF
  a_reset_empties: assert property (@(posedge clk) $past(rst) |-> !command.valid)
    else $error("command valid right after reset");

  a_last_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stage_v[NST-1] && !adv_out |=> stage_v[NST-1])
    else $error("stalled report lost before the result register");

  a_standup_cause: assert property (@(posedge clk) disable iff (rst)
    fire && std_req |-> fin.link_up && fin.report_valid &&
                        (rise[gmc_pkg::BTN_A] || rise[gmc_pkg::BTN_Y]))
    else $error("standup pulse without a button edge");

  a_jump_cause: assert property (@(posedge clk) disable iff (rst)
    fire && jump_req |-> fin.link_up && fin.report_valid && rise[gmc_pkg::BTN_B])
    else $error("jump pulse without a button edge");
`endif

endmodule
